/* rtl/dsib_pkg.sv */
// Shared types and constants for the depth sorted insert buffer.
package dsib_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int POS_W        = 7;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_DRAIN  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_DRAINED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic signed [KEY_W-1:0]  depth_key;
        logic        [TAG_W-1:0]  payload_tag;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [KEY_W-1:0]  out_key;
        logic        [TAG_W-1:0]  out_payload;
        logic        [POS_W-1:0]  out_position;
        logic                     last;
    } t_out_item;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;     // compare against new key, shift right, drop in new entry
        logic shift_out;  // move every entry one cell toward the head
    } t_cell_ctrl;

endpackage

/* rtl/dsib_cell.sv */
// One slot of the sorted chain: holds an entry, compares it, shifts it.
module dsib_cell (
    input  logic                               i_clk,
    input  dsib_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_occ,
    input  logic                               i_at_end,
    input  logic signed [dsib_pkg::KEY_W-1:0]  i_new_key,
    input  logic        [dsib_pkg::TAG_W-1:0]  i_new_tag,
    input  logic                               i_prev_lt,
    input  logic signed [dsib_pkg::KEY_W-1:0]  i_prev_key,
    input  logic        [dsib_pkg::TAG_W-1:0]  i_prev_tag,
    input  logic signed [dsib_pkg::KEY_W-1:0]  i_next_key,
    input  logic        [dsib_pkg::TAG_W-1:0]  i_next_tag,
    output logic                               o_lt,
    output logic                               o_take_new,
    output logic signed [dsib_pkg::KEY_W-1:0]  o_key,
    output logic        [dsib_pkg::TAG_W-1:0]  o_tag
);
    import dsib_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic        [TAG_W-1:0] r_tag;

    // Stored keys descend, so o_lt is a thermometer across occupied cells.
    assign o_lt       = i_occ && (r_key < i_new_key);
    assign o_take_new = !i_prev_lt && (o_lt || i_at_end);
    assign o_key      = r_key;
    assign o_tag      = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_prev_lt) begin
                r_key <= i_prev_key;
                r_tag <= i_prev_tag;
            end else if (o_take_new) begin
                r_key <= i_new_key;
                r_tag <= i_new_tag;
            end
        end else if (i_ctrl.shift_out) begin
            r_key <= i_next_key;
            r_tag <= i_next_tag;
        end
    end

endmodule

/* rtl/dsib_pos_enc.sv */
// One-hot to binary encoder for the slot that takes a new entry.
module dsib_pos_enc #(
    parameter int N = dsib_pkg::CAPACITY_DEF
) (
    input  logic [N-1:0]         i_onehot,
    output logic [$clog2(N)-1:0] o_pos
);
    import dsib_pkg::*;

    localparam int PW = $clog2(N);

    always_comb begin
        o_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (i_onehot[i]) begin
                o_pos = o_pos | PW'(i);
            end
        end
    end

endmodule

/* rtl/depth_sorted_insert_buffer.sv */
// Top level: chain of sorted cells, control sequencer and output register.
//
// Holds up to CAPACITY (key, tag) entries in descending signed key order in a
// row of compare-and-shift cells; equal keys keep arrival order. On an insert
// every cell compares the new key at once, the entries below the insertion
// slot move one cell down, and one result (inserted, or dropped when full) is
// written to the output register, so inserts sustain one per cycle while the
// output is not stalled. A drain of an empty buffer gives one empty result. A
// drain of N entries first enters the drain sequence, then gives one entry per
// cycle as the chain moves toward the head; input is stalled meanwhile. Output
// stall holds the chain.
// out_position carries the low 7 bits of the slot index.
module depth_sorted_insert_buffer #(
    parameter int CAPACITY = dsib_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dsib_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dsib_pkg::t_out_item o_out_data
);
    import dsib_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [PW-1:0]       r_drain_pos, n_drain_pos;
    logic                r_out_valid;
    t_out_item           r_out_data, n_out_data;
    logic                out_load;
    logic                out_free;
    t_cell_ctrl          cell_ctrl;

    logic signed [KEY_W-1:0] w_key [CAPACITY];
    logic        [TAG_W-1:0] w_tag [CAPACITY];
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_take_new;
    logic [PW-1:0]           w_pos;

    // ---------------------------------------------------------------- chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    prev_lt;
        logic signed [KEY_W-1:0] prev_key;
        logic        [TAG_W-1:0] prev_tag;
        logic signed [KEY_W-1:0] next_key;
        logic        [TAG_W-1:0] next_tag;

        if (g == 0) begin : g_head
            assign prev_lt  = 1'b0;
            assign prev_key = i_in_data.depth_key;
            assign prev_tag = i_in_data.payload_tag;
        end else begin : g_mid
            assign prev_lt  = w_lt[g-1];
            assign prev_key = w_key[g-1];
            assign prev_tag = w_tag[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_key = w_key[g];
            assign next_tag = w_tag[g];
        end else begin : g_body
            assign next_key = w_key[g+1];
            assign next_tag = w_tag[g+1];
        end

        dsib_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_occ      (CW'(g) < r_count),
            .i_at_end   (CW'(g) == r_count),
            .i_new_key  (i_in_data.depth_key),
            .i_new_tag  (i_in_data.payload_tag),
            .i_prev_lt  (prev_lt),
            .i_prev_key (prev_key),
            .i_prev_tag (prev_tag),
            .i_next_key (next_key),
            .i_next_tag (next_tag),
            .o_lt       (w_lt[g]),
            .o_take_new (w_take_new[g]),
            .o_key      (w_key[g]),
            .o_tag      (w_tag[g])
        );
    end

    dsib_pos_enc #(
        .N (CAPACITY)
    ) u_pos_enc (
        .i_onehot (w_take_new),
        .o_pos    (w_pos)
    );

    // -------------------------------------------------------------- control
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drain_pos = r_drain_pos;
        n_out_data  = r_out_data;
        out_load    = 1'b0;
        cell_ctrl   = '0;
        o_in_stall  = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_stall = !out_free;
                if (i_in_valid && out_free) begin
                    if (i_in_data.func == FN_INSERT) begin
                        out_load                = 1'b1;
                        n_out_data.out_key      = i_in_data.depth_key;
                        n_out_data.out_payload  = i_in_data.payload_tag;
                        n_out_data.last         = 1'b1;
                        if (r_count == CW'(CAPACITY)) begin
                            n_out_data.status       = ST_DROPPED;
                            n_out_data.out_position = '0;
                        end else begin
                            cell_ctrl.insert        = 1'b1;
                            n_count                 = r_count + 1'b1;
                            n_out_data.status       = ST_INSERTED;
                            n_out_data.out_position = POS_W'(w_pos);
                        end
                    end else if (r_count == '0) begin
                        out_load                = 1'b1;
                        n_out_data.status       = ST_EMPTY;
                        n_out_data.out_key      = '0;
                        n_out_data.out_payload  = '0;
                        n_out_data.out_position = '0;
                        n_out_data.last         = 1'b1;
                    end else begin
                        n_state     = S_DRAIN;
                        n_drain_pos = '0;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    cell_ctrl.shift_out     = 1'b1;
                    n_out_data.status       = ST_DRAINED;
                    n_out_data.out_key      = w_key[0];
                    n_out_data.out_payload  = w_tag[0];
                    n_out_data.out_position = POS_W'(r_drain_pos);
                    n_out_data.last         = (r_count == CW'(1));
                    n_count                 = r_count - 1'b1;
                    n_drain_pos             = r_drain_pos + 1'b1;
                    if (r_count == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_drain_pos <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drain_pos <= n_drain_pos;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ----------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.insert |-> $onehot(w_take_new))
        else $error("insert must pick exactly one slot");

    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> o_in_stall)
        else $error("input taken during drain");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && out_load && n_out_data.last)
        |=> (r_state == S_IDLE && r_count == '0))
        else $error("drain did not end empty");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("stalled result overwritten");

endmodule

/* bench/depth_sorted_insert_buffer_test.sv */
// Testbench for the depth sorted insert buffer: directed and random inserts and drains.
`timescale 1ns / 100ps

module depth_sorted_insert_buffer_test;
    import dsib_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int ITEM_TARGET = 355;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 80;
    localparam int IDLE_PCT    = 21;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // mirror of the sorted contents, head (largest key) first
    logic signed [KEY_W-1:0] shadow_keys[$];
    logic        [TAG_W-1:0] shadow_tags[$];
    t_out_item               buffer_reports[$];

    int idle_pct    = IDLE_PCT;
    int fail_count  = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    depth_sorted_insert_buffer #(.CAPACITY(CAPACITY)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic void push_report(input t_status st, input logic signed [KEY_W-1:0] key,
                                        input logic [TAG_W-1:0] tag, input int pos,
                                        input logic is_last);
        t_out_item r;
        r.status       = st;
        r.out_key      = key;
        r.out_payload  = tag;
        r.out_position = POS_W'(pos);
        r.last         = is_last;
        buffer_reports.insert(buffer_reports.size(), r);
    endfunction

    function automatic void apply_buffer_op(input t_in_item item);
        int pos;
        int n;
        if (item.func == FN_INSERT) begin
            if (shadow_keys.size() >= CAPACITY) begin
                push_report(ST_DROPPED, item.depth_key, item.payload_tag, 0, 1'b1);
                return;
            end
            pos = shadow_keys.size();
            // first stored key strictly below the new one; ties stay behind
            for (int i = 0; i < shadow_keys.size(); i++) begin
                if ($signed(shadow_keys[i]) < $signed(item.depth_key)) begin
                    pos = i;
                    break;
                end
            end
            shadow_keys.insert(pos, item.depth_key);
            shadow_tags.insert(pos, item.payload_tag);
            push_report(ST_INSERTED, item.depth_key, item.payload_tag, pos, 1'b1);
        end else begin
            n = shadow_keys.size();
            if (n == 0) begin
                push_report(ST_EMPTY, '0, '0, 0, 1'b1);
                return;
            end
            for (int i = 0; i < n; i++)
                push_report(ST_DRAINED, shadow_keys[i], shadow_tags[i], i, i == n - 1);
            shadow_keys.delete();
            shadow_tags.delete();
        end
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (buffer_reports.size() == 0) begin
            $error("unexpected result: status %0d key %0h payload %0h position %0d",
                   got.status, got.out_key, got.out_payload, got.out_position);
            fail_count++;
            return;
        end
        want = buffer_reports.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.out_key !== want.out_key) begin
            $error("out_key: expected %0h, actual %0h", want.out_key, got.out_key);
            fail_count++;
        end
        if (got.out_payload !== want.out_payload) begin
            $error("out_payload: expected %0h, actual %0h", want.out_payload, got.out_payload);
            fail_count++;
        end
        if (got.out_position !== want.out_position) begin
            $error("out_position: expected %0d, actual %0d",
                   want.out_position, got.out_position);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            fail_count++;
        end
    endtask

    // result side: sample before the edge updates, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_data);
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    task automatic send_item(input t_func fn, input logic signed [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        t_in_item item;
        item.func        = fn;
        item.depth_key   = key;
        item.payload_tag = tag;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        apply_buffer_op(item);
        items_sent++;
    endtask

    task automatic insert_entry(input logic signed [KEY_W-1:0] key, input logic [TAG_W-1:0] tag);
        send_item(FN_INSERT, key, tag);
    endtask

    task automatic drain_all();
        send_item(FN_DRAIN, KEY_W'($urandom), TAG_W'($urandom));
    endtask

    // full range, a narrow band that makes ties, or one of the extremes or a value at or next to zero
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return (int'($urandom_range(0, 6)) - 3) * 65536;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return 32'shFFFF_FFFF;
                    default: return 32'sh0000_0001;
                endcase
            end
        endcase
    endfunction

    task automatic test_directed();
        drain_all();                            // empty buffer
        insert_entry(32'sh0000_0000, 16'h0000);
        insert_entry(32'sh7FFF_FFFF, 16'hFFFF);
        insert_entry(32'sh8000_0000, 16'h0001);
        insert_entry(32'shFFFF_FFFF, 16'h0002);
        insert_entry(32'sh0000_0001, 16'h0003);
        insert_entry(32'sh0000_0000, 16'h0004); // tie lands behind the older zero
        insert_entry(32'sh0001_0000, 16'h0005);
        insert_entry(32'shFFFF_0000, 16'h0006);
        insert_entry(32'sh7FFF_FFFF, 16'h0007); // tie at the head
        insert_entry(32'sh8000_0000, 16'h0008); // tie at the tail
        drain_all();
        drain_all();
        insert_entry(32'sh1234_5678, 16'hA5A5);
        drain_all();                            // single entry
    endtask

    task automatic test_full_buffer();
        for (int i = 0; i < CAPACITY; i++)
            insert_entry(pick_key(), TAG_W'($urandom));
        insert_entry(32'sh7FFF_FFFF, 16'hFFFF); // dropped while full
        insert_entry(32'sh8000_0000, 16'h0000);
        insert_entry(pick_key(), TAG_W'($urandom));
        drain_all();
        insert_entry(pick_key(), TAG_W'($urandom));
        drain_all();
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        for (int round = 0; round < 3; round++) begin
            for (int i = 0; i < 12; i++)
                insert_entry(pick_key(), TAG_W'($urandom));
            drain_all();
        end
        drain_all();
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_mix();
        int count;
        int pick;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                count = $urandom_range(0, 10);
            else if (pick < 90)
                count = $urandom_range(11, 35);
            else
                count = $urandom_range(36, 70);
            for (int i = 0; i < count; i++)
                insert_entry(pick_key(), TAG_W'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                drain_all();
            end else if (pick < 85) begin
                drain_all();
                drain_all();
            end
        end
        drain_all();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_buffer();
        test_back_to_back();
        test_random_mix();
        i_in_valid <= 1'b0;
        while (buffer_reports.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
